### sv/packet_stats_hll_monitor_assert.svh
// assertion macros for the packet statistics monitor
// used by modules that assert; expects clk and rst_n in scope
`ifndef PACKET_STATS_HLL_MONITOR_ASSERT_SVH
`define PACKET_STATS_HLL_MONITOR_ASSERT_SVH
`ifndef SYNTHESIS
`define HMON_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hmon check failed");
`define HMON_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hmon check failed");
`else
`define HMON_ASSERT_IMP(lbl, ante, cons)
`define HMON_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### sv/hmon_pkg.sv
// shared types, constants and helpers for the packet statistics monitor
// no dependencies
package hmon_pkg;

    // sketch geometry
    localparam int P_BITS    = 6;
    localparam int NUM_REGS  = 1 << P_BITS;
    localparam int SK_AW     = P_BITS;
    localparam int RANK_CAP  = 32 - P_BITS;
    localparam int RANK_W    = 5;
    localparam int TZ_W      = 5;

    // associative tables
    localparam int SRC_ENTRIES  = 128;
    localparam int SRC_AW       = (SRC_ENTRIES > 1) ? $clog2(SRC_ENTRIES) : 1;
    localparam int SRC_FW       = $clog2(SRC_ENTRIES + 1);
    localparam int PORT_ENTRIES = 32;
    localparam int PORT_AW      = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int PORT_FW      = $clog2(PORT_ENTRIES + 1);
    localparam int IDX_W        = (SRC_FW > PORT_FW) ? SRC_FW : PORT_FW;

    // statistics counters
    localparam int NUM_CNT = 7;
    localparam int CNT_AW  = 3;
    localparam logic [CNT_AW-1:0] CNT_PASS  = 3'd0;
    localparam logic [CNT_AW-1:0] CNT_DROP  = 3'd1;
    localparam logic [CNT_AW-1:0] CNT_BYTES = 3'd2;
    localparam logic [CNT_AW-1:0] CNT_TCP   = 3'd3;
    localparam logic [CNT_AW-1:0] CNT_UDP   = 3'd4;
    localparam logic [CNT_AW-1:0] CNT_ICMP  = 3'd5;
    localparam logic [CNT_AW-1:0] CNT_OTHER = 3'd6;

    // field widths
    localparam int FUNC_W  = 3;
    localparam int LEN_W   = 16;
    localparam int ETYPE_W = 16;
    localparam int IP_W    = 32;
    localparam int PROTO_W = 8;
    localparam int PORT_W  = 16;
    localparam int RIDX_W  = 7;
    localparam int DATA_W  = 32;

    // function codes
    localparam logic [FUNC_W-1:0] FN_PACKET    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RD_CNT    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RD_SKETCH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_RD_SRC    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RD_PORT   = 3'd4;

    // header constants
    localparam logic [ETYPE_W-1:0] ETH_IPV4     = 16'h0800;
    localparam logic [LEN_W-1:0]   MIN_IPV4_LEN = 16'd34;
    localparam logic [LEN_W-1:0]   MIN_TCP_LEN  = 16'd54;
    localparam logic [LEN_W-1:0]   MIN_UDP_LEN  = 16'd42;
    localparam logic [PROTO_W-1:0] PROTO_ICMP   = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP    = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP    = 8'd17;
    localparam logic [IP_W-1:0]    HASH_MULT    = 32'd2654435761;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SRC_RD,
        ST_SRC_CMP,
        ST_SK_RD,
        ST_SK_WR,
        ST_PORT_RD,
        ST_PORT_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_item;
        logic start_pkt;
        logic idx_clr;
        logic idx_inc;
        logic src_rd;
        logic src_insert;
        logic src_incr;
        logic sk_rd;
        logic sk_upd;
        logic proto_cnt;
        logic port_rd;
        logic port_insert;
        logic port_incr;
        logic rd_mem;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              ipv4_ok;
        logic              proto_go;
        logic              port_go;
        logic              src_end;
        logic              src_match;
        logic              port_end;
        logic              port_match;
        logic              out_free;
    } dp_status_t;

    // rank = trailing zeros capped, plus one
    function automatic logic [RANK_W-1:0] rank_of(input logic [IP_W-1:0] h);
        logic [IP_W-1:0] low;
        logic [TZ_W-1:0] tz;
        logic [RANK_W-1:0] capped;
        low = h & (~h + 32'd1);
        tz  = '0;
        for (int b = 0; b < TZ_W; b++) begin
            for (int i = 0; i < IP_W; i++) begin
                if (i[b] && low[i]) begin
                    tz[b] = 1'b1;
                end
            end
        end
        if (h == '0 || 32'(tz) > RANK_CAP) begin
            capped = RANK_W'(RANK_CAP);
        end else begin
            capped = RANK_W'(tz);
        end
        return capped + RANK_W'(1);
    endfunction

endpackage

### sv/hmon_if.sv
// handshake channels of the packet statistics monitor
// depends on hmon_pkg for field widths
interface hmon_item_if;
    logic                           valid;
    logic                           ready;
    logic [hmon_pkg::FUNC_W-1:0]    func;
    logic [hmon_pkg::LEN_W-1:0]     pkt_len;
    logic [hmon_pkg::ETYPE_W-1:0]   ether_type;
    logic [hmon_pkg::IP_W-1:0]      src_ip;
    logic [hmon_pkg::PROTO_W-1:0]   ip_protocol;
    logic [hmon_pkg::PORT_W-1:0]    dst_port;
    logic [hmon_pkg::RIDX_W-1:0]    read_index;

    modport source (output valid, func, pkt_len, ether_type, src_ip, ip_protocol,
                    dst_port, read_index, input ready);
    modport sink (input valid, func, pkt_len, ether_type, src_ip, ip_protocol,
                  dst_port, read_index, output ready);
endinterface

interface hmon_result_if;
    logic                        valid;
    logic                        ready;
    logic                        drop;
    logic [hmon_pkg::DATA_W-1:0] read_value;
    logic [hmon_pkg::DATA_W-1:0] read_key;
    logic                        read_valid;
    logic                        ip_insert_failed;
    logic                        port_insert_failed;

    modport source (output valid, drop, read_value, read_key, read_valid,
                    ip_insert_failed, port_insert_failed, input ready);
    modport sink (input valid, drop, read_value, read_key, read_valid,
                  ip_insert_failed, port_insert_failed, output ready);
endinterface

interface hmon_cfg_if;
    logic valid;
    logic ready;
    logic drop_all;

    modport source (output valid, drop_all, input ready);
    modport sink (input valid, drop_all, output ready);
endinterface

### sv/hmon_ctrl.sv
// sequencing state machine of the packet statistics monitor
// depends on hmon_pkg and the assertion macro header
module hmon_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  hmon_pkg::dp_status_t st,
    output hmon_pkg::dp_cmd_t    cmd
);
    import hmon_pkg::*;
    `include "packet_stats_hll_monitor_assert.svh"

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_DONE;
                unique case (st.func)
                    FN_PACKET:
                    begin
                        cmd.start_pkt = 1'b1;
                        cmd.idx_clr   = 1'b1;
                        if (st.ipv4_ok)
                        begin
                            state_next = ST_SRC_RD;
                        end
                    end
                    FN_RD_CNT, FN_RD_SKETCH, FN_RD_SRC, FN_RD_PORT:
                    begin
                        cmd.rd_mem = 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SRC_RD:
            begin
                if (st.src_end)
                begin
                    cmd.src_insert = 1'b1;
                    state_next     = ST_SK_RD;
                end
                else
                begin
                    cmd.src_rd = 1'b1;
                    state_next = ST_SRC_CMP;
                end
            end
            ST_SRC_CMP:
            begin
                if (st.src_match)
                begin
                    cmd.src_incr = 1'b1;
                    state_next   = ST_SK_RD;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRC_RD;
                end
            end
            ST_SK_RD:
            begin
                cmd.sk_rd  = 1'b1;
                state_next = ST_SK_WR;
            end
            ST_SK_WR:
            begin
                cmd.sk_upd    = 1'b1;
                cmd.idx_clr   = 1'b1;
                cmd.proto_cnt = st.proto_go;
                state_next    = st.port_go ? ST_PORT_RD : ST_DONE;
            end
            ST_PORT_RD:
            begin
                if (st.port_end)
                begin
                    cmd.port_insert = 1'b1;
                    state_next      = ST_DONE;
                end
                else
                begin
                    cmd.port_rd = 1'b1;
                    state_next  = ST_PORT_CMP;
                end
            end
            ST_PORT_CMP:
            begin
                if (st.port_match)
                begin
                    cmd.port_incr = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_PORT_RD;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // an accepted word always moves on to decode
    `HMON_ASSERT_NXT(a_accept_decode, item_valid && item_ready, state_reg == ST_DECODE)

endmodule

### sv/hmon_dp.sv
// datapath of the packet statistics monitor: counters, sketch, tables, result register
// depends on hmon_pkg and the assertion macro header
module hmon_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  hmon_pkg::dp_cmd_t              cmd,
    output hmon_pkg::dp_status_t           st,
    input  logic                           cfg_we,
    input  logic                           cfg_drop_all,
    input  logic [hmon_pkg::FUNC_W-1:0]    func,
    input  logic [hmon_pkg::LEN_W-1:0]     pkt_len,
    input  logic [hmon_pkg::ETYPE_W-1:0]   ether_type,
    input  logic [hmon_pkg::IP_W-1:0]      src_ip,
    input  logic [hmon_pkg::PROTO_W-1:0]   ip_protocol,
    input  logic [hmon_pkg::PORT_W-1:0]    dst_port,
    input  logic [hmon_pkg::RIDX_W-1:0]    read_index,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           drop,
    output logic [hmon_pkg::DATA_W-1:0]    read_value,
    output logic [hmon_pkg::DATA_W-1:0]    read_key,
    output logic                           read_valid,
    output logic                           ip_insert_failed,
    output logic                           port_insert_failed
);
    import hmon_pkg::*;
    `include "packet_stats_hll_monitor_assert.svh"

    // configuration
    logic drop_all_reg;

    // latched item
    logic [FUNC_W-1:0]  func_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [ETYPE_W-1:0] etype_reg;
    logic [IP_W-1:0]    src_reg;
    logic [PROTO_W-1:0] proto_reg;
    logic [PORT_W-1:0]  dport_reg;
    logic [RIDX_W-1:0]  ridx_reg;

    // packet working state
    logic              verdict_reg;
    logic              ip_fail_reg;
    logic              port_fail_reg;
    logic [IP_W-1:0]   hash_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] cnt_reg [NUM_CNT];
    logic [DATA_W-1:0] cnt_next [NUM_CNT];

    // source table
    logic [IP_W-1:0]   src_key_mem [SRC_ENTRIES];
    logic [DATA_W-1:0] src_cnt_mem [SRC_ENTRIES];
    logic [IP_W-1:0]   src_key_q_reg;
    logic [DATA_W-1:0] src_cnt_q_reg;
    logic [SRC_FW-1:0] src_fill_reg;

    // port table
    logic [PORT_W-1:0]  port_key_mem [PORT_ENTRIES];
    logic [DATA_W-1:0]  port_cnt_mem [PORT_ENTRIES];
    logic [PORT_W-1:0]  port_key_q_reg;
    logic [DATA_W-1:0]  port_cnt_q_reg;
    logic [PORT_FW-1:0] port_fill_reg;

    // sketch registers
    logic [RANK_W-1:0]   sk_mem [NUM_REGS];
    logic [NUM_REGS-1:0] sk_valid_reg;
    logic [RANK_W-1:0]   sk_q_reg;
    logic                sk_vq_reg;

    // result register
    logic              out_valid_reg;
    logic              out_drop_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [DATA_W-1:0] out_key_reg;
    logic              out_rvalid_reg;
    logic              out_ipf_reg;
    logic              out_portf_reg;

    logic [IP_W-1:0]   hash_prod;
    logic [SK_AW-1:0]  hidx;
    logic              is_tcp;
    logic              is_udp;
    logic              proto_go;
    logic [CNT_AW-1:0] proto_idx;
    logic              src_full;
    logic              port_full;
    logic              src_we_key;
    logic              src_we_cnt;
    logic [SRC_AW-1:0] src_waddr;
    logic [SRC_AW-1:0] src_raddr;
    logic [DATA_W-1:0] src_cnt_wdata;
    logic               port_we_key;
    logic               port_we_cnt;
    logic [PORT_AW-1:0] port_waddr;
    logic [PORT_AW-1:0] port_raddr;
    logic [DATA_W-1:0]  port_cnt_wdata;
    logic [SK_AW-1:0]   sk_raddr;
    logic [RANK_W-1:0]  sk_cur;
    logic               sk_we;
    logic               res_drop;
    logic [DATA_W-1:0]  res_value;
    logic [DATA_W-1:0]  res_key;
    logic               res_rvalid;
    logic               res_ipf;
    logic               res_portf;

    // packet classification
    assign hash_prod = src_reg * HASH_MULT;
    assign hidx      = hash_reg[IP_W-1 -: P_BITS];
    assign is_tcp    = (proto_reg == PROTO_TCP);
    assign is_udp    = (proto_reg == PROTO_UDP);
    assign proto_go  = !(is_tcp && len_reg < MIN_TCP_LEN) && !(is_udp && len_reg < MIN_UDP_LEN);

    always_comb
    begin
        priority if (is_tcp)
        begin
            proto_idx = CNT_TCP;
        end
        else if (is_udp)
        begin
            proto_idx = CNT_UDP;
        end
        else if (proto_reg == PROTO_ICMP)
        begin
            proto_idx = CNT_ICMP;
        end
        else
        begin
            proto_idx = CNT_OTHER;
        end
    end

    // status to the controller
    assign src_full  = (src_fill_reg == SRC_FW'(SRC_ENTRIES));
    assign port_full = (port_fill_reg == PORT_FW'(PORT_ENTRIES));
    always_comb
    begin
        st.func       = func_reg;
        st.ipv4_ok    = (len_reg >= MIN_IPV4_LEN) && (etype_reg == ETH_IPV4);
        st.proto_go   = proto_go;
        st.port_go    = proto_go && (is_tcp || is_udp) && (dport_reg != '0);
        st.src_end    = (idx_reg == IDX_W'(src_fill_reg));
        st.src_match  = (src_key_q_reg == src_reg);
        st.port_end   = (idx_reg == IDX_W'(port_fill_reg));
        st.port_match = (port_key_q_reg == dport_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_all_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            drop_all_reg <= cfg_drop_all;
        end
    end

    // item latch and packet working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg  <= func;
            len_reg   <= pkt_len;
            etype_reg <= ether_type;
            src_reg   <= src_ip;
            proto_reg <= ip_protocol;
            dport_reg <= dst_port;
            ridx_reg  <= read_index;
        end
        if (cmd.start_pkt)
        begin
            verdict_reg <= drop_all_reg;
            hash_reg    <= hash_prod;
        end
        if (cmd.sk_rd)
        begin
            rank_reg <= rank_of(hash_reg);
        end
    end

    // failure flags and scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_fail_reg   <= 1'b0;
            port_fail_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                ip_fail_reg   <= 1'b0;
                port_fail_reg <= 1'b0;
            end
            if (cmd.src_insert && src_full)
            begin
                ip_fail_reg <= 1'b1;
            end
            if (cmd.port_insert && port_full)
            begin
                port_fail_reg <= 1'b1;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // statistics counters
    always_comb
    begin
        for (int i = 0; i < NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
        end
        if (cmd.start_pkt)
        begin
            cnt_next[CNT_AW'(drop_all_reg)] = cnt_reg[CNT_AW'(drop_all_reg)] + 32'd1;
            cnt_next[CNT_BYTES] = cnt_reg[CNT_BYTES] + DATA_W'(len_reg);
        end
        if (cmd.proto_cnt)
        begin
            cnt_next[proto_idx] = cnt_reg[proto_idx] + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // source table: entries fill in slot order, so the fill count marks validity
    assign src_we_key    = cmd.src_insert && !src_full;
    assign src_we_cnt    = src_we_key || cmd.src_incr;
    assign src_waddr     = cmd.src_insert ? src_fill_reg[SRC_AW-1:0] : idx_reg[SRC_AW-1:0];
    assign src_cnt_wdata = cmd.src_insert ? 32'd1 : src_cnt_q_reg + 32'd1;
    assign src_raddr     = cmd.rd_mem ? SRC_AW'(ridx_reg) : idx_reg[SRC_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (src_we_key)
        begin
            src_key_mem[src_waddr] <= src_reg;
        end
        if (src_we_cnt)
        begin
            src_cnt_mem[src_waddr] <= src_cnt_wdata;
        end
        if (cmd.src_rd || cmd.rd_mem)
        begin
            src_key_q_reg <= src_key_mem[src_raddr];
            src_cnt_q_reg <= src_cnt_mem[src_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_fill_reg <= '0;
        end
        else if (src_we_key)
        begin
            src_fill_reg <= src_fill_reg + SRC_FW'(1);
        end
    end

    // port table, same scheme
    assign port_we_key    = cmd.port_insert && !port_full;
    assign port_we_cnt    = port_we_key || cmd.port_incr;
    assign port_waddr     = cmd.port_insert ? port_fill_reg[PORT_AW-1:0]
                                            : idx_reg[PORT_AW-1:0];
    assign port_cnt_wdata = cmd.port_insert ? 32'd1 : port_cnt_q_reg + 32'd1;
    assign port_raddr     = cmd.rd_mem ? PORT_AW'(ridx_reg) : idx_reg[PORT_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (port_we_key)
        begin
            port_key_mem[port_waddr] <= dport_reg;
        end
        if (port_we_cnt)
        begin
            port_cnt_mem[port_waddr] <= port_cnt_wdata;
        end
        if (cmd.port_rd || cmd.rd_mem)
        begin
            port_key_q_reg <= port_key_mem[port_raddr];
            port_cnt_q_reg <= port_cnt_mem[port_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_fill_reg <= '0;
        end
        else if (port_we_key)
        begin
            port_fill_reg <= port_fill_reg + PORT_FW'(1);
        end
    end

    // sketch registers: read, then write back the maximum
    assign sk_raddr = cmd.rd_mem ? SK_AW'(ridx_reg) : hidx;
    assign sk_cur   = sk_vq_reg ? sk_q_reg : '0;
    assign sk_we    = cmd.sk_upd && (rank_reg > sk_cur);

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[hidx] <= rank_reg;
        end
        if (cmd.sk_rd || cmd.rd_mem)
        begin
            sk_q_reg  <= sk_mem[sk_raddr];
            sk_vq_reg <= sk_valid_reg[sk_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_valid_reg <= '0;
        end
        else if (sk_we)
        begin
            sk_valid_reg[hidx] <= 1'b1;
        end
    end

    // result word
    always_comb
    begin
        res_drop   = 1'b0;
        res_value  = '0;
        res_key    = '0;
        res_rvalid = 1'b0;
        res_ipf    = 1'b0;
        res_portf  = 1'b0;
        unique case (func_reg)
            FN_PACKET:
            begin
                res_drop  = verdict_reg;
                res_ipf   = ip_fail_reg;
                res_portf = port_fail_reg;
            end
            FN_RD_CNT:
            begin
                if (32'(ridx_reg) < NUM_CNT)
                begin
                    res_value = cnt_reg[CNT_AW'(ridx_reg)];
                end
            end
            FN_RD_SKETCH:
            begin
                if (32'(ridx_reg) < NUM_REGS)
                begin
                    res_value = DATA_W'(sk_cur);
                end
            end
            FN_RD_SRC:
            begin
                if (32'(ridx_reg) < 32'(src_fill_reg))
                begin
                    res_value  = src_cnt_q_reg;
                    res_key    = src_key_q_reg;
                    res_rvalid = 1'b1;
                end
            end
            FN_RD_PORT:
            begin
                if (32'(ridx_reg) < 32'(port_fill_reg))
                begin
                    res_value  = port_cnt_q_reg;
                    res_key    = DATA_W'(port_key_q_reg);
                    res_rvalid = 1'b1;
                end
            end
            default:
            begin
                res_drop = 1'b0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_drop_reg   <= res_drop;
            out_value_reg  <= res_value;
            out_key_reg    <= res_key;
            out_rvalid_reg <= res_rvalid;
            out_ipf_reg    <= res_ipf;
            out_portf_reg  <= res_portf;
        end
    end

    assign out_valid          = out_valid_reg;
    assign drop               = out_drop_reg;
    assign read_value         = out_value_reg;
    assign read_key           = out_key_reg;
    assign read_valid         = out_rvalid_reg;
    assign ip_insert_failed   = out_ipf_reg;
    assign port_insert_failed = out_portf_reg;

    // a waiting word is never overwritten
    `HMON_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_reg || out_ready)
    // fill counts stay within the tables
    `HMON_ASSERT_IMP(a_src_fill, 1'b1, 32'(src_fill_reg) <= SRC_ENTRIES)
    `HMON_ASSERT_IMP(a_port_fill, 1'b1, 32'(port_fill_reg) <= PORT_ENTRIES)

endmodule

### sv/packet_stats_hll_monitor.sv
// top level of the packet statistics monitor with distinct-source sketch
// depends on hmon_pkg, the hmon interfaces, hmon_ctrl and hmon_dp
//
//   channel   role   words
//   item      sink   packet summaries and read requests
//   result    source one result word per item
//   cfg       sink   drop_all setting, always ready
//
// reads, unused codes, short and non-ipv4 packets go from decode straight to done.
// ipv4 packets step through the source table, the sketch and, for tcp and udp, the port table,
// comparing slot by slot, since each table slot needs a registered memory read before its compare;
// a table scan ends at a match or with an insert attempt past the last filled slot.
// reset clears counters, fill counts and sketch valid bits at once; no clearing pass.
// a finished word waits in the output register while the next item is accepted;
// a word still held there when the next result is ready stalls the block in its done state.
module packet_stats_hll_monitor (
    input logic       clk,
    input logic       rst_n,
    hmon_item_if.sink item,
    hmon_result_if.source result,
    hmon_cfg_if.sink  cfg
);
    import hmon_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    // configuration is taken at any time
    assign cfg.ready = 1'b1;

    // sequencer
    hmon_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .st         (st),
        .cmd        (cmd)
    );

    // datapath
    hmon_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .cfg_we             (cfg.valid),
        .cfg_drop_all       (cfg.drop_all),
        .func               (item.func),
        .pkt_len            (item.pkt_len),
        .ether_type         (item.ether_type),
        .src_ip             (item.src_ip),
        .ip_protocol        (item.ip_protocol),
        .dst_port           (item.dst_port),
        .read_index         (item.read_index),
        .out_ready          (result.ready),
        .out_valid          (result.valid),
        .drop               (result.drop),
        .read_value         (result.read_value),
        .read_key           (result.read_key),
        .read_valid         (result.read_valid),
        .ip_insert_failed   (result.ip_insert_failed),
        .port_insert_failed (result.port_insert_failed)
    );

endmodule
